@@ rtl/peer_link_table_macros.svh @@
// Assertion macros shared by the peer link table RTL.
`ifndef PEER_LINK_TABLE_MACROS_SVH
`define PEER_LINK_TABLE_MACROS_SVH

// Check a property at every clock edge outside reset.
`define PLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property at every clock edge, during reset too.
`define PLT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/plt_pkg.sv @@
package plt_pkg;

  typedef enum logic [2:0] {
    MODE_ANN   = 3'd0,
    MODE_CONN  = 3'd1,
    MODE_ACC   = 3'd2,
    MODE_DISC  = 3'd3,
    MODE_LCONN = 3'd4,
    MODE_LDISC = 3'd5,
    MODE_TICK  = 3'd6,
    MODE_NONE  = 3'd7
  } mode_e;

  localparam logic [2:0] SEND_NONE = 3'd0;
  localparam logic [2:0] SEND_ANN  = 3'd1;
  localparam logic [2:0] SEND_CONN = 3'd2;
  localparam logic [2:0] SEND_ACC  = 3'd3;
  localparam logic [2:0] SEND_DISC = 3'd4;

  localparam logic [1:0] NOTE_NONE = 2'd0;
  localparam logic [1:0] NOTE_SEEN = 2'd1;
  localparam logic [1:0] NOTE_LINK = 2'd2;

  localparam logic [1:0] LINK_DISC = 2'd0;
  localparam logic [1:0] LINK_CONNECTING = 2'd1;
  localparam logic [1:0] LINK_CONNECTED = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_OWN     = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_ACTIVE  = 3'd4;

  localparam logic [1:0] CFG_LOCAL_ID  = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT   = 2'd1;
  localparam logic [1:0] CFG_ANN_IVL   = 2'd2;

  // Timeout results a single tick may report.
  localparam int unsigned TmoCap = 8;
  localparam logic [3:0] TMO_CAP = 4'd8;
  localparam logic [3:0] CNT_MAX = 4'd15;

  // Token that walks the cell row, one cell a cycle.
  typedef struct packed {
    logic                vld;
    mode_e               mode;
    logic                own;
    logic [31:0]         dev;
    logic [31:0]         sip;
    logic [31:0]         now;
    logic                ann;
    logic                found;
    logic                is_new;
    logic [2:0]          idx;
    logic [1:0]          old;
    logic [31:0]         ip;
    logic [3:0]          cnt;
    logic [3:0]          tmo_n;
    logic [TmoCap-1:0][2:0] tmo_idx;
    logic [TmoCap-1:0][1:0] tmo_old;
  } tok_t;

endpackage

@@ rtl/plt_cell.sv @@
module plt_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [31:0]   tmo_limit_i,
  input  plt_pkg::tok_t tok_i,
  output plt_pkg::tok_t tok_o
);

  logic          used_q, used_d;
  logic [31:0]   id_q, ip_q, seen_q;
  logic [1:0]    link_q, link_d;
  plt_pkg::tok_t tok_q, t;
  logic          alloc, refresh, id_hit, ip_hit, stale;

  assign id_hit = used_q && (id_q == tok_i.dev);
  assign ip_hit = used_q && (ip_q == tok_i.sip);
  assign stale  = used_q && ((tok_i.now - seen_q) > tmo_limit_i) &&
                  (link_q != plt_pkg::LINK_DISC);

  always_comb begin
    t       = tok_i;
    used_d  = used_q;
    link_d  = link_q;
    alloc   = 1'b0;
    refresh = 1'b0;
    if (tok_i.vld) begin
      case (tok_i.mode)
        plt_pkg::MODE_ANN: begin
          if (!tok_i.own && !tok_i.found) begin
            if (id_hit) begin
              refresh = 1'b1;
              t.found = 1'b1;
              t.idx   = 3'(IDX);
              t.old   = link_q;
            end else if (!used_q) begin
              alloc    = 1'b1;
              t.found  = 1'b1;
              t.is_new = 1'b1;
              t.idx    = 3'(IDX);
              t.old    = plt_pkg::LINK_DISC;
              used_d   = 1'b1;
              link_d   = plt_pkg::LINK_DISC;
            end
          end
        end
        plt_pkg::MODE_CONN, plt_pkg::MODE_DISC: begin
          if (!tok_i.found && ip_hit) begin
            t.found = 1'b1;
            t.idx   = 3'(IDX);
            t.old   = link_q;
            link_d  = (tok_i.mode == plt_pkg::MODE_DISC) ? plt_pkg::LINK_DISC
                                                         : plt_pkg::LINK_CONNECTED;
          end
        end
        plt_pkg::MODE_ACC: begin
          if (!tok_i.found && ip_hit && link_q == plt_pkg::LINK_CONNECTING) begin
            t.found = 1'b1;
            t.idx   = 3'(IDX);
            t.old   = link_q;
            link_d  = plt_pkg::LINK_CONNECTED;
          end
        end
        plt_pkg::MODE_LCONN, plt_pkg::MODE_LDISC: begin
          if (!tok_i.found && id_hit) begin
            t.found = 1'b1;
            t.idx   = 3'(IDX);
            t.old   = link_q;
            t.ip    = ip_q;
            if (tok_i.mode == plt_pkg::MODE_LDISC) begin
              link_d = plt_pkg::LINK_DISC;
            end else if (link_q == plt_pkg::LINK_DISC) begin
              link_d = plt_pkg::LINK_CONNECTING;
            end
          end
        end
        plt_pkg::MODE_TICK: begin
          if (stale) begin
            link_d = plt_pkg::LINK_DISC;
            if (tok_i.tmo_n < plt_pkg::TMO_CAP) begin
              t.tmo_idx[tok_i.tmo_n[2:0]] = 3'(IDX);
              t.tmo_old[tok_i.tmo_n[2:0]] = link_q;
              t.tmo_n = tok_i.tmo_n + 4'd1;
            end
          end
        end
        default: ;
      endcase
      // Count live links after this cell's update.
      if (used_d && link_d[1] && t.cnt != plt_pkg::CNT_MAX) begin
        t.cnt = t.cnt + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      tok_q  <= '0;
    end else begin
      used_q <= used_d;
      tok_q  <= t;
    end
  end

  always_ff @(posedge clk_i) begin
    link_q <= link_d;
    if (alloc) begin
      id_q <= tok_i.dev;
    end
    if (alloc || refresh) begin
      ip_q   <= tok_i.sip;
      seen_q <= tok_i.now;
    end
  end

  assign tok_o = tok_q;

endmodule

@@ rtl/peer_link_table.sv @@
// An item walks the row of NUM_SLOTS cells, one cell a cycle, and is captured in hold_q;
//   its result beats then pass out through the output register.
// A new item is taken only once all R result beats of the last (R from 1 to 9) have been
//   loaded, one result beat a cycle while the output is not stalled.
// Reset: table empty, announce stamp zero, local_id 0, timeout 15000, announce interval 5000.
module peer_link_table #(
  parameter int unsigned NUM_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  mode_i,
  input  logic [31:0] device_id_i,
  input  logic [31:0] source_ip_i,
  input  logic [31:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  send_kind_o,
  output logic [31:0] dest_ip_o,
  output logic [1:0]  notify_kind_o,
  output logic [2:0]  peer_index_o,
  output logic [1:0]  old_state_o,
  output logic [1:0]  new_state_o,
  output logic        is_new_o,
  output logic [2:0]  status_o,
  output logic [3:0]  connected_count_o,
  output logic        last_o
);

`include "peer_link_table_macros.svh"

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_EMIT} state_e;

  typedef struct packed {
    logic [2:0]  send;
    logic [31:0] dest;
    logic [1:0]  note;
    logic [2:0]  idx;
    logic [1:0]  olds;
    logic [1:0]  news;
    logic        is_new;
    logic [2:0]  status;
    logic [3:0]  cnt;
    logic        last;
  } res_t;

  state_e        state_q;
  logic [31:0]   local_id_q, tmo_limit_q, ann_ivl_q, stamp_q;
  plt_pkg::tok_t chain [NUM_SLOTS+1];
  plt_pkg::tok_t inj, hold_q;
  logic [3:0]    emit_q;
  logic          accept, ann_due, load;
  logic [NUM_SLOTS-1:0] tok_vld;
  res_t          res, out_q;
  logic          out_vld_q;
  logic [4:0]    tick_sum;
  logic [3:0]    total;

  // Take a new item only with no token in flight and no beats left to emit.
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign ann_due    = (now_ms_i - stamp_q) >= ann_ivl_q;

  // Build the token that enters cell 0.
  always_comb begin
    inj      = '0;
    inj.vld  = accept;
    inj.mode = plt_pkg::mode_e'(mode_i);
    inj.own  = (device_id_i == local_id_q);
    inj.dev  = device_id_i;
    inj.sip  = source_ip_i;
    inj.now  = now_ms_i;
    inj.ann  = (mode_i == plt_pkg::MODE_TICK) && ann_due;
  end

  assign chain[0] = inj;

  // Row of cells; each holds one table slot and passes the token on.
  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    plt_cell #(.IDX(g)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .tmo_limit_i (tmo_limit_q),
      .tok_i       (chain[g]),
      .tok_o       (chain[g+1])
    );
    assign tok_vld[g] = chain[g+1].vld;
  end

  // Number of beats the captured item produces.
  assign tick_sum = {1'b0, hold_q.tmo_n} + 5'(hold_q.ann);
  always_comb begin
    if (hold_q.mode == plt_pkg::MODE_TICK && tick_sum != 5'd0) begin
      total = tick_sum[3:0];
    end else begin
      total = 4'd1;
    end
  end

  // Decode the result beat selected by emit_q.
  always_comb begin
    res        = '0;
    res.cnt    = hold_q.cnt;
    res.last   = (emit_q == total - 4'd1);
    case (hold_q.mode)
      plt_pkg::MODE_ANN: begin
        if (hold_q.own) begin
          res.status = plt_pkg::ST_OWN;
        end else if (!hold_q.found) begin
          res.status = plt_pkg::ST_FULL;
        end else begin
          res.note   = plt_pkg::NOTE_SEEN;
          res.idx    = hold_q.idx;
          res.olds   = hold_q.old;
          res.news   = hold_q.old;
          res.is_new = hold_q.is_new;
        end
      end
      plt_pkg::MODE_CONN, plt_pkg::MODE_ACC, plt_pkg::MODE_DISC: begin
        if (!hold_q.found) begin
          res.status = plt_pkg::ST_UNKNOWN;
        end else begin
          res.note = plt_pkg::NOTE_LINK;
          res.idx  = hold_q.idx;
          res.olds = hold_q.old;
          res.news = (hold_q.mode == plt_pkg::MODE_DISC) ? plt_pkg::LINK_DISC
                                                         : plt_pkg::LINK_CONNECTED;
          if (hold_q.mode == plt_pkg::MODE_CONN) begin
            res.send = plt_pkg::SEND_ACC;
            res.dest = hold_q.sip;
          end
        end
      end
      plt_pkg::MODE_LCONN: begin
        if (!hold_q.found) begin
          res.status = plt_pkg::ST_UNKNOWN;
        end else if (hold_q.old != plt_pkg::LINK_DISC) begin
          res.status = plt_pkg::ST_ACTIVE;
          res.idx    = hold_q.idx;
          res.olds   = hold_q.old;
          res.news   = hold_q.old;
        end else begin
          res.send = plt_pkg::SEND_CONN;
          res.dest = hold_q.ip;
          res.note = plt_pkg::NOTE_LINK;
          res.idx  = hold_q.idx;
          res.news = plt_pkg::LINK_CONNECTING;
        end
      end
      plt_pkg::MODE_LDISC: begin
        if (!hold_q.found) begin
          res.status = plt_pkg::ST_UNKNOWN;
        end else if (hold_q.old == plt_pkg::LINK_DISC) begin
          res.idx = hold_q.idx;
        end else begin
          res.send = plt_pkg::SEND_DISC;
          res.dest = hold_q.ip;
          res.note = plt_pkg::NOTE_LINK;
          res.idx  = hold_q.idx;
          res.olds = hold_q.old;
        end
      end
      plt_pkg::MODE_TICK: begin
        if (emit_q < hold_q.tmo_n) begin
          res.note = plt_pkg::NOTE_LINK;
          res.idx  = hold_q.tmo_idx[emit_q[2:0]];
          res.olds = hold_q.tmo_old[emit_q[2:0]];
        end else if (hold_q.ann) begin
          res.send = plt_pkg::SEND_ANN;
          res.dest = '1;
        end
      end
      default: ;
    endcase
  end

  assign load = (state_q == ST_EMIT) && (!out_vld_q || !out_stall_i);

  // Sequencer, configuration registers and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      local_id_q  <= '0;
      tmo_limit_q <= 32'd15000;
      ann_ivl_q   <= 32'd5000;
      stamp_q     <= '0;
      emit_q      <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          plt_pkg::CFG_LOCAL_ID: local_id_q  <= cfg_data_i;
          plt_pkg::CFG_TIMEOUT:  tmo_limit_q <= cfg_data_i;
          plt_pkg::CFG_ANN_IVL:  ann_ivl_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept && inj.ann) begin
        stamp_q <= now_ms_i;
      end
      // Load a new beat, or drop the one just taken.
      if (load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (chain[NUM_SLOTS].vld) begin
            emit_q  <= '0;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (load) begin
            emit_q <= emit_q + 4'd1;
            if (res.last) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RUN && chain[NUM_SLOTS].vld) begin
      hold_q <= chain[NUM_SLOTS];
    end
    if (load) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign send_kind_o       = out_q.send;
  assign dest_ip_o         = out_q.dest;
  assign notify_kind_o     = out_q.note;
  assign peer_index_o      = out_q.idx;
  assign old_state_o       = out_q.olds;
  assign new_state_o       = out_q.news;
  assign is_new_o          = out_q.is_new;
  assign status_o          = out_q.status;
  assign connected_count_o = out_q.cnt;
  assign last_o            = out_q.last;

  `PLT_ASSERT(a_one_token, $onehot0(tok_vld), "more than one token in the cell row")
  `PLT_ASSERT(a_accept_enters, accept |=> chain[1].vld, "accepted item did not enter cell 0")
  `PLT_ASSERT(a_idle_no_token, (state_q == ST_IDLE) |-> (tok_vld == '0),
              "token in flight while idle")
  `PLT_ASSERT(a_emit_bound, (state_q == ST_EMIT) |-> (emit_q < total),
              "beat index past result count")

endmodule

@@ tb/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NPEERS = 8;
  localparam int unsigned STALL_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]  send;
    logic [31:0] dest;
    logic [1:0]  note;
    logic [2:0]  idx;
    logic [1:0]  olds;
    logic [1:0]  news;
    logic        fresh;
    logic [2:0]  stat;
    logic [3:0]  cnt;
    logic        fin;
  } beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  mode_i = '0;
  logic [31:0] device_id_i = '0;
  logic [31:0] source_ip_i = '0;
  logic [31:0] now_ms_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  send_kind_o;
  logic [31:0] dest_ip_o;
  logic [1:0]  notify_kind_o;
  logic [2:0]  peer_index_o;
  logic [1:0]  old_state_o;
  logic [1:0]  new_state_o;
  logic        is_new_o;
  logic [2:0]  status_o;
  logic [3:0]  connected_count_o;
  logic        last_o;

  peer_link_table #(.NUM_SLOTS(NPEERS)) dut (.*);

  always #5 clk_i = ~clk_i;

  // Shadow copy of the peer table and its registers.
  logic [31:0] my_id, tmo_limit, ann_ivl, ann_stamp;
  logic [31:0] peer_id [NPEERS];
  logic [31:0] peer_ip [NPEERS];
  logic [31:0] peer_seen [NPEERS];
  logic [1:0]  peer_link [NPEERS];
  int unsigned peer_cnt;

  beat_t expected_beats[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit          hold_off = 1'b0;
  bit          timed_out = 1'b0;
  logic [31:0] clock_ms = 0;

  function automatic beat_t mk(logic [2:0] s, logic [31:0] d, logic [1:0] n, int i,
                               logic [1:0] o, logic [1:0] w, logic f, logic [2:0] st);
    beat_t b;
    b = '{send: s, dest: d, note: n, idx: i[2:0], olds: o, news: w, fresh: f,
          stat: st, cnt: 4'd0, fin: 1'b0};
    return b;
  endfunction

  function automatic int slot_of_id(logic [31:0] id);
    for (int i = 0; i < peer_cnt; i++) if (peer_id[i] == id) return i;
    return -1;
  endfunction

  function automatic int slot_of_ip(logic [31:0] ip, bit want_connecting);
    for (int i = 0; i < peer_cnt; i++)
      if (peer_ip[i] == ip &&
          (!want_connecting || peer_link[i] == plt_pkg::LINK_CONNECTING))
        return i;
    return -1;
  endfunction

  // Advance the shadow table by one message and queue the beats it yields.
  function automatic void predict_beats(plt_pkg::mode_e m, logic [31:0] dev,
                                        logic [31:0] sip, logic [31:0] now);
    beat_t res[$];
    int s;
    int tmo_n;
    logic [1:0] o;
    logic [3:0] cc;
    tmo_n = 0;
    cc = 0;
    case (m)
      plt_pkg::MODE_ANN: begin
        if (dev == my_id)
          res.push_back(mk(plt_pkg::SEND_NONE, 0, plt_pkg::NOTE_NONE, 0, 0, 0, 0,
                           plt_pkg::ST_OWN));
        else begin
          s = slot_of_id(dev);
          if (s < 0 && peer_cnt >= NPEERS)
            res.push_back(mk(plt_pkg::SEND_NONE, 0, plt_pkg::NOTE_NONE, 0, 0, 0, 0,
                             plt_pkg::ST_FULL));
          else if (s < 0) begin
            s = peer_cnt;
            peer_cnt++;
            peer_id[s] = dev; peer_ip[s] = sip; peer_seen[s] = now;
            peer_link[s] = plt_pkg::LINK_DISC;
            res.push_back(mk(plt_pkg::SEND_NONE, 0, plt_pkg::NOTE_SEEN, s, 0, 0, 1,
                             plt_pkg::ST_OK));
          end else begin
            peer_ip[s] = sip; peer_seen[s] = now;
            res.push_back(mk(plt_pkg::SEND_NONE, 0, plt_pkg::NOTE_SEEN, s, peer_link[s],
                             peer_link[s], 0, plt_pkg::ST_OK));
          end
        end
      end
      plt_pkg::MODE_CONN, plt_pkg::MODE_ACC, plt_pkg::MODE_DISC: begin
        s = slot_of_ip(sip, m == plt_pkg::MODE_ACC);
        if (s < 0)
          res.push_back(mk(plt_pkg::SEND_NONE, 0, plt_pkg::NOTE_NONE, 0, 0, 0, 0,
                           plt_pkg::ST_UNKNOWN));
        else begin
          o = peer_link[s];
          peer_link[s] = (m == plt_pkg::MODE_DISC) ? plt_pkg::LINK_DISC
                                                   : plt_pkg::LINK_CONNECTED;
          res.push_back(mk(m == plt_pkg::MODE_CONN ? plt_pkg::SEND_ACC : plt_pkg::SEND_NONE,
                           m == plt_pkg::MODE_CONN ? sip : 32'd0, plt_pkg::NOTE_LINK, s,
                           o, peer_link[s], 0, plt_pkg::ST_OK));
        end
      end
      plt_pkg::MODE_LCONN, plt_pkg::MODE_LDISC: begin
        s = slot_of_id(dev);
        if (s < 0)
          res.push_back(mk(plt_pkg::SEND_NONE, 0, plt_pkg::NOTE_NONE, 0, 0, 0, 0,
                           plt_pkg::ST_UNKNOWN));
        else begin
          o = peer_link[s];
          if (m == plt_pkg::MODE_LCONN) begin
            if (o != plt_pkg::LINK_DISC)
              res.push_back(mk(plt_pkg::SEND_NONE, 0, plt_pkg::NOTE_NONE, s, o, o, 0,
                               plt_pkg::ST_ACTIVE));
            else begin
              peer_link[s] = plt_pkg::LINK_CONNECTING;
              res.push_back(mk(plt_pkg::SEND_CONN, peer_ip[s], plt_pkg::NOTE_LINK, s, 0,
                               plt_pkg::LINK_CONNECTING, 0, plt_pkg::ST_OK));
            end
          end else if (o == plt_pkg::LINK_DISC)
            res.push_back(mk(plt_pkg::SEND_NONE, 0, plt_pkg::NOTE_NONE, s, 0, 0, 0,
                             plt_pkg::ST_OK));
          else begin
            peer_link[s] = plt_pkg::LINK_DISC;
            res.push_back(mk(plt_pkg::SEND_DISC, peer_ip[s], plt_pkg::NOTE_LINK, s, o, 0,
                             0, plt_pkg::ST_OK));
          end
        end
      end
      plt_pkg::MODE_TICK: begin
        for (int i = 0; i < peer_cnt; i++) begin
          if (32'(now - peer_seen[i]) > tmo_limit && peer_link[i] != plt_pkg::LINK_DISC)
          begin
            o = peer_link[i];
            peer_link[i] = plt_pkg::LINK_DISC;
            if (tmo_n < 8)
              res.push_back(mk(plt_pkg::SEND_NONE, 0, plt_pkg::NOTE_LINK, i, o, 0, 0,
                               plt_pkg::ST_OK));
            tmo_n++;
          end
        end
        if (32'(now - ann_stamp) >= ann_ivl) begin
          ann_stamp = now;
          res.push_back(mk(plt_pkg::SEND_ANN, 32'hFFFF_FFFF, plt_pkg::NOTE_NONE, 0, 0, 0,
                           0, plt_pkg::ST_OK));
        end
        if (res.size() == 0)
          res.push_back(mk(plt_pkg::SEND_NONE, 0, plt_pkg::NOTE_NONE, 0, 0, 0, 0,
                           plt_pkg::ST_OK));
      end
      default: res.push_back(mk(plt_pkg::SEND_NONE, 0, plt_pkg::NOTE_NONE, 0, 0, 0, 0,
                                plt_pkg::ST_OK));
    endcase
    for (int i = 0; i < peer_cnt; i++) if (peer_link[i] >= plt_pkg::LINK_CONNECTED) cc++;
    foreach (res[j]) begin
      res[j].cnt = cc;
      res[j].fin = (j == res.size() - 1);
      expected_beats.push_back(res[j]);
    end
  endfunction

  // Offer one message after a random gap; hold it until the block takes it.
  task automatic send_msg(plt_pkg::mode_e m, logic [31:0] dev, logic [31:0] sip,
                          logic [31:0] now);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= m;
    device_id_i <= dev;
    source_ip_i <= sip;
    now_ms_i <= now;
    do @(posedge clk_i); while (in_stall_o);
    predict_beats(m, dev, sip, now);
  endtask

  // Drop valid once the last message has been taken.
  task automatic release_input();
    in_valid_i <= 1'b0;
  endtask

  // Registers change only while the block is idle.
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    release_input();
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      plt_pkg::CFG_LOCAL_ID: my_id = val;
      plt_pkg::CFG_TIMEOUT:  tmo_limit = val;
      default:               ann_ivl = val;
    endcase
  endtask

  // Result side: random wait per beat, plus a forced hold-off window.
  initial begin
    int w;
    @(posedge rst_ni);
    forever begin
      w = $urandom_range(0, 5);
      if (w != 0) begin
        out_stall_i <= 1'b1;
        repeat (w) @(posedge clk_i);
      end
      while (hold_off) begin
        out_stall_i <= 1'b1;
        @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // Compare each result beat against the oldest expectation.
  always @(posedge clk_i) begin
    beat_t got, exp_b;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{send: send_kind_o, dest: dest_ip_o, note: notify_kind_o, idx: peer_index_o,
              olds: old_state_o, news: new_state_o, fresh: is_new_o, stat: status_o,
              cnt: connected_count_o, fin: last_o};
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        exp_b = expected_beats.pop_front();
        if (got !== exp_b) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp_b, got);
        end
      end
    end
  end

  // Watchdog: count cycles without any accepted message or result beat while work is pending.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (!in_valid_i && expected_beats.size() == 0))
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_dev();
    if (peer_cnt > 0 && $urandom_range(0, 9) < 7) return peer_id[$urandom_range(0, peer_cnt-1)];
    return $urandom_range(0, 11) + 32'h100;
  endfunction

  function automatic logic [31:0] pick_ip();
    if (peer_cnt > 0 && $urandom_range(0, 9) < 7) return peer_ip[$urandom_range(0, peer_cnt-1)];
    return $urandom();
  endfunction

  task automatic test_directed();
    send_msg(plt_pkg::MODE_ANN, 32'd0, 32'h0A00_0001, 0);            // own id after reset
    send_msg(plt_pkg::MODE_CONN, 0, 32'h0A00_0001, 0);               // unknown peer
    send_msg(plt_pkg::MODE_ANN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_msg(plt_pkg::MODE_ANN, 32'h1, 32'h0, 10);
    send_msg(plt_pkg::MODE_ANN, 32'h1, 32'hC0A8_0001, 20);           // refresh
    send_msg(plt_pkg::MODE_LCONN, 32'h1, 0, 30);
    send_msg(plt_pkg::MODE_LCONN, 32'h1, 0, 30);                     // already active
    send_msg(plt_pkg::MODE_ACC, 0, 32'hC0A8_0001, 40);
    send_msg(plt_pkg::MODE_ACC, 0, 32'hC0A8_0001, 40);               // not connecting
    send_msg(plt_pkg::MODE_LDISC, 32'h1, 0, 50);
    send_msg(plt_pkg::MODE_LDISC, 32'h1, 0, 50);                     // already down
    send_msg(plt_pkg::MODE_DISC, 0, 32'hC0A8_0001, 60);              // already down
    send_msg(plt_pkg::MODE_CONN, 0, 32'hFFFF_FFFF, 70);
    send_msg(plt_pkg::MODE_LDISC, 32'h9999, 0, 70);
    send_msg(plt_pkg::MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    for (int i = 0; i < 8; i++) send_msg(plt_pkg::MODE_ANN, 32'h20 + i, 32'h20 + i, 100);
    send_msg(plt_pkg::MODE_ANN, 32'h77, 32'h77, 100);                // table full
    send_msg(plt_pkg::MODE_TICK, 0, 0, 32'hFFFF_FFFF);               // wrap, announce
  endtask

  // Connect every peer, then let one tick time all of them out.
  task automatic test_mass_timeout();
    for (int i = 0; i < NPEERS; i++) send_msg(plt_pkg::MODE_CONN, 0, peer_ip[i], 0);
    send_msg(plt_pkg::MODE_TICK, 0, 0, clock_ms + 32'd100000);
  endtask

  task automatic test_random(int n);
    int r;
    logic [31:0] dev;
    for (int k = 0; k < n; k++) begin
      clock_ms += $urandom_range(0, 3000);
      r = $urandom_range(0, 99);
      dev = pick_dev();
      if (r < 30) send_msg(plt_pkg::MODE_ANN, $urandom_range(0, 15) == 0 ? my_id : dev,
                           pick_ip(), $urandom_range(0, 19) == 0 ? $urandom() : clock_ms);
      else if (r < 40) send_msg(plt_pkg::MODE_CONN, $urandom(), pick_ip(), clock_ms);
      else if (r < 50) send_msg(plt_pkg::MODE_ACC, $urandom(), pick_ip(), clock_ms);
      else if (r < 57) send_msg(plt_pkg::MODE_DISC, $urandom(), pick_ip(), clock_ms);
      else if (r < 70) send_msg(plt_pkg::MODE_LCONN, dev, $urandom(), clock_ms);
      else if (r < 78) send_msg(plt_pkg::MODE_LDISC, dev, $urandom(), clock_ms);
      else if (r < 98) send_msg(plt_pkg::MODE_TICK, $urandom(), $urandom(), clock_ms);
      else send_msg(plt_pkg::MODE_NONE, $urandom(), $urandom(), $urandom());
    end
  endtask

  // Hold the result side off while messages keep coming, so the input stalls.
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      test_random(12);
    join
  endtask

  initial begin
    my_id = 0; tmo_limit = 15000; ann_ivl = 5000; ann_stamp = 0; peer_cnt = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    write_reg(plt_pkg::CFG_TIMEOUT, 32'd0);
    test_mass_timeout();
    write_reg(plt_pkg::CFG_LOCAL_ID, 32'h105);
    write_reg(plt_pkg::CFG_TIMEOUT, 32'd4000);
    write_reg(plt_pkg::CFG_ANN_IVL, 32'd1);
    test_random(90);
    test_backpressure();
    write_reg(plt_pkg::CFG_LOCAL_ID, 32'hFFFF_FFFF);
    write_reg(plt_pkg::CFG_TIMEOUT, 32'hFFFF_FFFF);
    write_reg(plt_pkg::CFG_ANN_IVL, 32'hFFFF_FFFF);
    test_random(70);
    write_reg(plt_pkg::CFG_TIMEOUT, 32'd9000);
    write_reg(plt_pkg::CFG_ANN_IVL, 32'd0);
    write_reg(plt_pkg::CFG_LOCAL_ID, 32'h0);
    test_random(100);
    release_input();
    fork
      while (expected_beats.size() != 0) @(posedge clk_i);
      begin
        repeat (100000) @(posedge clk_i);
        timed_out = 1'b1;
      end
    join_any
    disable fork;
    repeat (40) @(posedge clk_i);
    if (!timed_out && mismatches == 0 && expected_beats.size() == 0)
      $display("tb_top passed");
    else
      $display("tb_top failed");
    $finish;
  end
endmodule
